FILE: design/lfs_pkg.sv
package lfs_pkg;

    // buffer depth default
    localparam int FRAME_BYTES_DEF = 16;

    // field widths
    localparam int OPCODE_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int TIMEOUT_W = 20;
    localparam int MASK_W    = 2;
    localparam int CFG_IDX_W = 2;

    // input opcodes
    localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BREAK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIBBLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE    = 2'd2;

    // timeout reset value and idle counter limit
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd2000;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX    = 20'hFFFFF;

    // bus phases
    localparam logic [1:0] PH_WAIT_BREAK = 2'd0;
    localparam logic [1:0] PH_WAIT_SYNC  = 2'd1;
    localparam logic [1:0] PH_WAIT_PID   = 2'd2;
    localparam logic [1:0] PH_DATA       = 2'd3;

    // frame status codes
    localparam logic [STATUS_W-1:0] STAT_HEADER   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PARITY   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_CLASSIC  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ENHANCED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CSUM_ERR = 3'd4;

    // special bytes and ids
    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] BREAK_BYTE = 8'h00;
    localparam logic [5:0]        ID_DIAG_RQ = 6'h3C;
    localparam logic [5:0]        ID_DIAG_RS = 6'h3D;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   frame_pid;
        logic                byte_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] frame_status;
        logic                overflow_flag;
        logic                last;
    } out_item_t;

    // one's complement add with end-around carry
    function automatic logic [BYTE_W-1:0] add_carry(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[BYTE_W]) begin
            add_carry = s[BYTE_W-1:0] + 8'd1;
        end else begin
            add_carry = s[BYTE_W-1:0];
        end
    endfunction

    // pid parity bits p0 (bit 6) and p1 (bit 7, inverted)
    function automatic logic parity_good(input logic [BYTE_W-1:0] p);
        logic p0;
        logic p1;
        p0 = p[0] ^ p[1] ^ p[2] ^ p[4];
        p1 = ~(p[1] ^ p[3] ^ p[4] ^ p[5]);
        parity_good = (p[6] == p0) && (p[7] == p1);
    endfunction

endpackage

FILE: design/lin_frame_sniffer_unit.sv
// Passive LIN frame monitor. Input beats (received byte, break or
// one-microsecond tick) are taken one per cycle while the sequencer is
// idle. When the idle timeout ends a frame with n stored bytes whose ID
// passes the filter, the block walks its frame buffer once to build the
// classic and enhanced checksums (a header-only frame skips this), judges
// the status, then presents one result per cycle while the output is taken
// (n-1 results, or a single one for a header-only or checksum-only frame).
// A frame that fails the filter is dropped. Input ready stays low for the
// whole report, and configuration writes are taken in any cycle.
module lin_frame_sniffer_unit
    import lfs_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIMEOUT_W-1:0]  cfg_data
);

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SUM   = 2'd1;
    localparam logic [1:0] ST_JUDGE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [BYTE_W-1:0]    nibbles_reg;
    logic [MASK_W-1:0]    care_reg;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           phase_reg, phase_next;
    logic [BYTE_W-1:0]    pid_reg, pid_next;
    logic                 par_ok_reg, par_ok_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 ovf_reg, ovf_next;
    logic [TIMEOUT_W-1:0] idle_reg, idle_next;

    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [BYTE_W-1:0]    cl_reg, cl_next;
    logic [BYTE_W-1:0]    en_reg, en_next;
    logic [BYTE_W-1:0]    rcv_reg, rcv_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic [BYTE_W-1:0]    mem [FRAME_BYTES];
    logic [BYTE_W-1:0]    mem_q;
    logic                 mem_we;

    logic                 in_fire;
    logic                 out_free;
    logic                 load;
    logic [CNT_W-1:0]     payload;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic [5:0]           frame_id;
    logic                 id_pass;
    logic                 diag;
    logic                 has_bytes;
    logic                 is_last;
    out_item_t            result;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign load      = (state_reg == ST_EMIT) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // frame decode helpers
    assign payload  = fill_reg - CNT_W'(1);
    assign idle_inc = (idle_reg < IDLE_MAX) ? idle_reg + TIMEOUT_W'(1) : idle_reg;
    assign frame_id = pid_reg[5:0];
    assign diag     = (frame_id == ID_DIAG_RQ) || (frame_id == ID_DIAG_RS);
    assign id_pass  = (!care_reg[0] || (nibbles_reg[7:4] == {2'b00, frame_id[5:4]})) &&
                      (!care_reg[1] || (nibbles_reg[3:0] == frame_id[3:0]));

    // result assembly for the emit state
    assign has_bytes = (fill_reg != '0) && (payload != '0);
    assign is_last   = !has_bytes ||
                       ((CNT_W+1)'(addr_reg) + (CNT_W+1)'(1) == (CNT_W+1)'(payload));
    always_comb begin
        result.frame_pid     = pid_reg;
        result.byte_valid    = has_bytes;
        result.data_byte     = has_bytes ? mem_q : '0;
        result.frame_status  = status_reg;
        result.overflow_flag = (fill_reg != '0) && ovf_reg;
        result.last          = is_last;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            nibbles_reg <= '0;
            care_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_NIBBLES: nibbles_reg <= cfg_data[BYTE_W-1:0];
                REG_CARE:    care_reg    <= cfg_data[MASK_W-1:0];
                default:     ;
            endcase
        end
    end

    // frame tracking and report sequencer
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        pid_next    = pid_reg;
        par_ok_next = par_ok_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        idle_next   = idle_reg;
        addr_next   = addr_reg;
        cl_next     = cl_reg;
        en_next     = en_reg;
        rcv_next    = rcv_reg;
        status_next = status_reg;
        mem_we      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_data.opcode)
                        OP_BREAK: begin
                            phase_next  = PH_WAIT_SYNC;
                            pid_next    = '0;
                            par_ok_next = 1'b0;
                            fill_next   = '0;
                            ovf_next    = 1'b0;
                            idle_next   = '0;
                        end
                        OP_BYTE: begin
                            case (phase_reg)
                                PH_WAIT_BREAK: begin
                                    if (s_data.rx_byte == BREAK_BYTE) begin
                                        phase_next  = PH_WAIT_SYNC;
                                        pid_next    = '0;
                                        par_ok_next = 1'b0;
                                        fill_next   = '0;
                                        ovf_next    = 1'b0;
                                        idle_next   = '0;
                                    end else if (s_data.rx_byte == SYNC_BYTE) begin
                                        phase_next = PH_WAIT_PID;
                                    end
                                end
                                PH_WAIT_SYNC: begin
                                    if (s_data.rx_byte == SYNC_BYTE) begin
                                        phase_next = PH_WAIT_PID;
                                    end else if (s_data.rx_byte != BREAK_BYTE) begin
                                        phase_next  = PH_WAIT_BREAK;
                                        pid_next    = '0;
                                        par_ok_next = 1'b0;
                                        fill_next   = '0;
                                        ovf_next    = 1'b0;
                                        idle_next   = '0;
                                    end
                                end
                                PH_WAIT_PID: begin
                                    pid_next    = s_data.rx_byte;
                                    par_ok_next = parity_good(s_data.rx_byte);
                                    fill_next   = '0;
                                    phase_next  = PH_DATA;
                                    idle_next   = '0;
                                end
                                default: begin
                                    if (fill_reg < CNT_W'(FRAME_BYTES)) begin
                                        mem_we    = 1'b1;
                                        fill_next = fill_reg + CNT_W'(1);
                                    end else begin
                                        ovf_next = 1'b1;
                                    end
                                    idle_next = '0;
                                end
                            endcase
                        end
                        OP_TICK: begin
                            if (phase_reg == PH_DATA) begin
                                idle_next = idle_inc;
                                if (idle_inc >= timeout_reg) begin
                                    addr_next = '0;
                                    if (!id_pass) begin
                                        phase_next  = PH_WAIT_BREAK;
                                        pid_next    = '0;
                                        par_ok_next = 1'b0;
                                        fill_next   = '0;
                                        ovf_next    = 1'b0;
                                        idle_next   = '0;
                                    end else if (fill_reg == '0) begin
                                        status_next = STAT_HEADER;
                                        state_next  = ST_EMIT;
                                    end else begin
                                        cl_next    = '0;
                                        en_next    = pid_reg;
                                        state_next = ST_SUM;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // one stored byte per cycle; the last one is the checksum
            ST_SUM: begin
                if (CNT_W'(addr_reg) == payload) begin
                    rcv_next   = mem_q;
                    state_next = ST_JUDGE;
                end else begin
                    cl_next   = add_carry(cl_reg, mem_q);
                    en_next   = add_carry(en_reg, mem_q);
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_JUDGE: begin
                if (!par_ok_reg) begin
                    status_next = STAT_PARITY;
                end else if (diag && (~cl_reg == rcv_reg)) begin
                    status_next = STAT_CLASSIC;
                end else if (!diag && (~en_reg == rcv_reg)) begin
                    status_next = STAT_ENHANCED;
                end else begin
                    status_next = STAT_CSUM_ERR;
                end
                addr_next  = '0;
                state_next = ST_EMIT;
            end
            default: begin
                if (load) begin
                    if (is_last) begin
                        state_next  = ST_IDLE;
                        phase_next  = PH_WAIT_BREAK;
                        pid_next    = '0;
                        par_ok_next = 1'b0;
                        fill_next   = '0;
                        ovf_next    = 1'b0;
                        idle_next   = '0;
                    end else begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_WAIT_BREAK;
            pid_reg    <= '0;
            par_ok_reg <= 1'b0;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            idle_reg   <= '0;
            addr_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pid_reg    <= pid_next;
            par_ok_reg <= par_ok_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            idle_reg   <= idle_next;
            addr_reg   <= addr_next;
        end
    end

    // checksum datapath
    always_ff @(posedge aclk) begin
        cl_reg     <= cl_next;
        en_reg     <= en_next;
        rcv_reg    <= rcv_next;
        status_reg <= status_next;
    end

    // frame buffer, read data is registered from the next address
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg[ADDR_W-1:0]] <= s_data.rx_byte;
        end
        mem_q <= mem[addr_next];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result;
        end
    end

endmodule
